FILE: rtl/bgps_pkg.sv
// Package: types, constants and register map of the button gesture power sequencer.
package bgps_pkg;

  localparam int HISTORY_RUNS     = 5;
  localparam int SETTLE_READS     = 20;
  localparam int DEBOUNCE_SAMPLES = 4;

  localparam int RUN_W   = 11;
  localparam int CMP_W   = 12;
  localparam int TIMER_W = 15;
  localparam int CNT_W   = 5;
  localparam int ADDR_W  = 5;

  typedef logic signed [RUN_W-1:0] run_t;
  typedef logic signed [CMP_W-1:0] cmp_t;

  localparam run_t RUN_SAT_POS = run_t'(1023);
  localparam run_t RUN_SAT_NEG = run_t'(-1023);
  localparam run_t RUN_ONE     = run_t'(1);
  localparam run_t RUN_MINUS   = run_t'(-1);

  localparam logic [TIMER_W-1:0] TIMER_MAX   = {TIMER_W{1'b1}};
  localparam logic [CNT_W-1:0]   SETTLE_LAST = CNT_W'(SETTLE_READS);

  typedef enum logic [2:0] {
    MODE_INITIAL   = 3'd0,
    MODE_SETTLING  = 3'd1,
    MODE_RECORDING = 3'd2,
    MODE_IDLE      = 3'd3,
    MODE_OFF       = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    ACT_NONE          = 4'd0,
    ACT_START_LINK    = 4'd1,
    ACT_START_REC     = 4'd2,
    ACT_STOP_REC_OFF  = 4'd3,
    ACT_STOP_REC_LINK = 4'd4,
    ACT_REC_FINISHED  = 4'd5,
    ACT_INVALID_WAKE  = 4'd6,
    ACT_IDLE_TIMEOUT  = 4'd7,
    ACT_SINGLE_CLICK  = 4'd8,
    ACT_NOT_PIN_WAKE  = 4'd9
  } action_t;

  localparam logic [2:0] REG_WOKE_BY_BUTTON = 3'd0;
  localparam logic [2:0] REG_LONG_PRESS     = 3'd1;
  localparam logic [2:0] REG_CLICK_MIN      = 3'd2;
  localparam logic [2:0] REG_CLICK_MAX      = 3'd3;
  localparam logic [2:0] REG_IDLE_TIMEOUT   = 3'd4;

  localparam logic [9:0]         RST_LONG_PRESS   = 10'd200;
  localparam logic [9:0]         RST_CLICK_MIN    = 10'd8;
  localparam logic [9:0]         RST_CLICK_MAX    = 10'd30;
  localparam logic [TIMER_W-1:0] RST_IDLE_TIMEOUT = TIMER_W'(18000);

endpackage

FILE: rtl/button_gesture_power_sequencer.sv
// Button gesture power sequencer: debounce, run history, gesture decode and mode machine.
// Throughput: one word per cycle unless the master side stalls; the input register feeds
// a single pass of gesture and mode logic into the result register, and the state updates
// on the same edge.
// Reset (rst, synchronous): mode initial, debounce window all ones, history
// 0,0,0,0,1, counters cleared, registers at their defaults, both stream sides empty.
module button_gesture_power_sequencer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // button_pin, subscription_on, recording_finished
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // action[3:0], mode[6:4]
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bgps_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bgps_pkg::*;

  logic                 woke_by_button;
  logic [9:0]           long_press_ticks;
  logic [9:0]           click_min;
  logic [9:0]           click_max;
  logic [TIMER_W-1:0]   idle_timeout_ticks;

  logic                 in_valid;
  logic                 in_pin;
  logic                 in_sub;
  logic                 in_fin;
  logic                 out_valid;
  action_t              out_action;
  mode_t                out_mode;
  logic                 advance;

  logic [DEBOUNCE_SAMPLES-1:0] window, window_next, win_s;
  run_t                 hist [HISTORY_RUNS];
  run_t                 hist_next [HISTORY_RUNS];
  run_t                 hist_s [HISTORY_RUNS];
  mode_t                mode, mode_next;
  action_t              action;
  logic [CNT_W-1:0]     settle_count, settle_count_next, cnt_inc;
  logic                 settle_target, settle_target_next;
  logic [TIMER_W-1:0]   idle_timer, idle_timer_next, timer_upd;

  logic                 s_pos, s_neg, extend;
  run_t                 nw, nw_ext;
  cmp_t                 cmin, cmax, lpt;
  cmp_t                 hx [8];
  cmp_t                 h0, h1, h2, h3;
  logic [2:0]           hsel;
  logic                 hold_hit, tap_once, tap_twice, in_progress;
  logic                 cfg_write;

  function automatic cmp_t ext(input run_t v);
    ext = {v[RUN_W-1], v};
  endfunction

  function automatic logic in_click(input cmp_t v, input cmp_t lo, input cmp_t hi);
    in_click = (lo < v) && (v < hi);
  endfunction

  function automatic logic in_gap(input cmp_t v, input cmp_t lo, input cmp_t hi);
    in_gap = (-hi < v) && (v < -lo);
  endfunction

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      woke_by_button     <= 1'b1;
      long_press_ticks   <= RST_LONG_PRESS;
      click_min          <= RST_CLICK_MIN;
      click_max          <= RST_CLICK_MAX;
      idle_timeout_ticks <= RST_IDLE_TIMEOUT;
    end else if (cfg_write) begin
      case (paddr[ADDR_W-1:2])
        REG_WOKE_BY_BUTTON: woke_by_button     <= pwdata[0];
        REG_LONG_PRESS:     long_press_ticks   <= pwdata[9:0];
        REG_CLICK_MIN:      click_min          <= pwdata[9:0];
        REG_CLICK_MAX:      click_max          <= pwdata[9:0];
        REG_IDLE_TIMEOUT:   idle_timeout_ticks <= pwdata[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_WOKE_BY_BUTTON: prdata = {31'd0, woke_by_button};
      REG_LONG_PRESS:     prdata = {22'd0, long_press_ticks};
      REG_CLICK_MIN:      prdata = {22'd0, click_min};
      REG_CLICK_MAX:      prdata = {22'd0, click_max};
      REG_IDLE_TIMEOUT:   prdata = {{(32-TIMER_W){1'b0}}, idle_timeout_ticks};
      default:            prdata = 32'd0;
    endcase
  end

  // stream handshake
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_mode, out_action};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_pin <= s_axis_tdata[0];
      in_sub <= s_axis_tdata[1];
      in_fin <= s_axis_tdata[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_action <= action;
      out_mode   <= mode_next;
    end
  end

  // debounce and run history after one sample
  always_comb begin
    win_s  = {window[DEBOUNCE_SAMPLES-2:0], ~in_pin};
    s_pos  = &win_s;
    s_neg  = ~|win_s;
    nw     = hist[HISTORY_RUNS-1];
    extend = !(s_pos || s_neg) || (s_pos && nw > 0) || (s_neg && nw < 0);
    if (nw > 0) begin
      nw_ext = (nw < RUN_SAT_POS) ? run_t'(nw + RUN_ONE) : nw;
    end else begin
      nw_ext = (nw > RUN_SAT_NEG) ? run_t'(nw - RUN_ONE) : nw;
    end
    for (int i = 0; i < HISTORY_RUNS - 1; i++) begin
      hist_s[i] = extend ? hist[i] : hist[i+1];
    end
    if (extend) begin
      hist_s[HISTORY_RUNS-1] = nw_ext;
    end else begin
      hist_s[HISTORY_RUNS-1] = s_pos ? RUN_ONE : RUN_MINUS;
    end
  end

  // gesture decode on the updated history
  always_comb begin
    cmin = cmp_t'({2'b00, click_min});
    cmax = cmp_t'({2'b00, click_max});
    lpt  = cmp_t'({2'b00, long_press_ticks});
    for (int i = 0; i < 8; i++) begin
      hx[i] = (i < HISTORY_RUNS) ? ext(hist_s[i % HISTORY_RUNS]) : cmp_t'(0);
    end
    hold_hit  = ext(hist_s[4]) == lpt;
    tap_once  = (ext(hist_s[2]) < -cmax) && in_click(ext(hist_s[3]), cmin, cmax)
                && (hist_s[4] == RUN_MINUS);
    tap_twice = ((hist_s[0] == '0) || (ext(hist_s[0]) < -cmax))
                && in_click(ext(hist_s[1]), cmin, cmax)
                && in_gap(ext(hist_s[2]), cmin, cmax)
                && in_click(ext(hist_s[3]), cmin, cmax)
                && (hist_s[4] == RUN_MINUS);
    priority if (hist_s[3] == '0) hsel = 3'd4;
    else if (hist_s[2] == '0)     hsel = 3'd3;
    else if (hist_s[1] == '0)     hsel = 3'd2;
    else if (hist_s[0] == '0)     hsel = 3'd1;
    else                          hsel = 3'd0;
    h0 = hx[hsel];
    h1 = hx[3'(hsel + 3'd1)];
    h2 = hx[3'(hsel + 3'd2)];
    h3 = hx[3'(hsel + 3'd3)];
    in_progress = ((0 < h0) && (h0 < lpt) && (h1 == 0))
                  || ((0 < h0) && (h0 < cmax) && (h1 == 0))
                  || (in_click(h0, cmin, cmax) && (-cmax < h1) && (h1 < 0) && (h2 == 0))
                  || (in_click(h0, cmin, cmax) && in_gap(h1, cmin, cmax)
                      && (0 < h2) && (h2 < cmax) && (h3 == 0));
  end

  // mode machine
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_INITIAL;
      window        <= {DEBOUNCE_SAMPLES{1'b1}};
      for (int i = 0; i < HISTORY_RUNS - 1; i++) begin
        hist[i] <= '0;
      end
      hist[HISTORY_RUNS-1] <= RUN_ONE;
      settle_count  <= '0;
      settle_target <= 1'b0;
      idle_timer    <= '0;
    end else if (advance) begin
      mode          <= mode_next;
      window        <= window_next;
      hist          <= hist_next;
      settle_count  <= settle_count_next;
      settle_target <= settle_target_next;
      idle_timer    <= idle_timer_next;
    end
  end

  always_comb begin
    mode_next          = mode;
    action             = ACT_NONE;
    window_next        = window;
    hist_next          = hist;
    settle_count_next  = settle_count;
    settle_target_next = settle_target;
    idle_timer_next    = idle_timer;
    cnt_inc            = CNT_W'(settle_count + 1'b1);
    if (in_sub) begin
      timer_upd = '0;
    end else begin
      timer_upd = (idle_timer < TIMER_MAX) ? TIMER_W'(idle_timer + 1'b1) : idle_timer;
    end
    unique case (mode)
      MODE_INITIAL: begin
        if (!woke_by_button) begin
          action    = ACT_NOT_PIN_WAKE;
          mode_next = MODE_OFF;
        end else begin
          window_next = win_s;
          hist_next   = hist_s;
          if (hold_hit) begin
            mode_next          = MODE_SETTLING;
            settle_target_next = 1'b0;
            settle_count_next  = '0;
          end else if (tap_twice) begin
            mode_next          = MODE_SETTLING;
            settle_target_next = 1'b1;
            settle_count_next  = '0;
          end else if (!in_progress) begin
            action    = ACT_INVALID_WAKE;
            mode_next = MODE_OFF;
          end
        end
      end
      MODE_SETTLING: begin
        window_next = win_s;
        hist_next   = hist_s;
        if (cnt_inc >= SETTLE_LAST) begin
          settle_count_next = '0;
          if (settle_target) begin
            action    = ACT_START_REC;
            mode_next = MODE_RECORDING;
          end else begin
            action          = ACT_START_LINK;
            mode_next       = MODE_IDLE;
            idle_timer_next = '0;
          end
        end else begin
          settle_count_next = cnt_inc;
        end
      end
      MODE_RECORDING: begin
        window_next = win_s;
        hist_next   = hist_s;
        if (in_fin) begin
          action    = ACT_REC_FINISHED;
          mode_next = MODE_OFF;
        end else if (tap_twice) begin
          action    = ACT_STOP_REC_OFF;
          mode_next = MODE_OFF;
        end else if (hold_hit) begin
          action          = ACT_STOP_REC_LINK;
          mode_next       = MODE_IDLE;
          idle_timer_next = '0;
        end
      end
      MODE_IDLE: begin
        idle_timer_next = timer_upd;
        if (timer_upd > idle_timeout_ticks) begin
          action    = ACT_IDLE_TIMEOUT;
          mode_next = MODE_OFF;
        end else begin
          window_next = win_s;
          hist_next   = hist_s;
          if (tap_once) begin
            action    = ACT_SINGLE_CLICK;
            mode_next = MODE_OFF;
          end
        end
      end
      default: begin
        mode_next = MODE_OFF;
      end
    endcase
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking stream testbench for the button gesture power sequencer.
`timescale 1ns / 1ps

module tb_top;
  import bgps_pkg::*;

  localparam int DIR_N        = 25;
  localparam int CHOKE_CYCLES = 150;

  typedef struct packed {
    action_t act;
    mode_t   mode;
  } result_t;

  typedef struct packed {
    logic    fin;
    logic    sub;
    logic    pin;
    logic    typed;
    result_t want;
  } dir_row_t;

  localparam result_t NO_WANT = '{ACT_NONE, MODE_INITIAL};

  // Initial mode: a click of 4, a gap of 4 and a second click of 4 make a double click,
  // then the settling reads follow.
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{1'b0, 1'b0, 1'b1, 1'b1, '{ACT_NONE, MODE_INITIAL}},
    '{1'b1, 1'b0, 1'b1, 1'b0, NO_WANT},
    '{1'b0, 1'b1, 1'b1, 1'b0, NO_WANT},
    '{1'b1, 1'b1, 1'b1, 1'b0, NO_WANT},
    '{1'b0, 1'b0, 1'b0, 1'b0, NO_WANT},
    '{1'b1, 1'b0, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 1'b1, 1'b0, 1'b0, NO_WANT},
    '{1'b1, 1'b1, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 1'b0, 1'b1, 1'b0, NO_WANT},
    '{1'b1, 1'b1, 1'b1, 1'b0, NO_WANT},
    '{1'b0, 1'b1, 1'b1, 1'b0, NO_WANT},
    '{1'b1, 1'b0, 1'b1, 1'b0, NO_WANT},
    '{1'b1, 1'b1, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 1'b0, 1'b0, 1'b0, NO_WANT},
    '{1'b1, 1'b0, 1'b1, 1'b0, NO_WANT},
    '{1'b0, 1'b1, 1'b1, 1'b0, NO_WANT},
    '{1'b1, 1'b1, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 1'b0, 1'b1, 1'b0, NO_WANT},
    '{1'b1, 1'b0, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 1'b1, 1'b0, 1'b0, NO_WANT},
    '{1'b1, 1'b1, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 1'b0, 1'b1, 1'b0, NO_WANT},
    '{1'b1, 1'b0, 1'b1, 1'b0, NO_WANT},
    '{1'b0, 1'b1, 1'b1, 1'b0, NO_WANT},
    '{1'b1, 1'b1, 1'b0, 1'b0, NO_WANT}
  };

  logic              clk;
  logic              rst           = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;  // button_pin, subscription_on, recording_finished
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;        // action[3:0], mode[6:4]
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;

  button_gesture_power_sequencer u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // sequencer state as predicted
  logic [DEBOUNCE_SAMPLES-1:0] win;
  run_t                        runs [HISTORY_RUNS];
  mode_t                       pmode;
  logic [CNT_W-1:0]            settle_cnt;
  logic                        settle_to_rec;
  logic [TIMER_W-1:0]          idle_cnt;
  logic                        cfg_woke;
  logic [9:0]                  cfg_long;
  logic [9:0]                  cfg_cmin;
  logic [9:0]                  cfg_cmax;
  logic [TIMER_W-1:0]          cfg_tmo;

  result_t    pending_results [$];
  int         words_checked = 0;
  int         mismatches    = 0;
  int         items_sent    = 0;
  int         reg_writes    = 0;
  int         cycle_count   = 0;
  int         choke_left    = 0;
  bit         choke_req     = 1'b0;
  bit         calm          = 1'b0;
  logic [9:0] act_seen      = '0;
  logic [4:0] mode_seen     = '0;
  logic       lvl           = 1'b1;
  int         burst_left    = 0;
  logic       sub_lvl       = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("** button_gesture_power_sequencer: FAILED **");
    $finish;
  end

  function automatic int run_at(int i);
    if (i < 0 || i >= HISTORY_RUNS) return 0;
    return int'(runs[i]);
  endfunction

  function automatic bit click_len(int v);
    return int'(cfg_cmin) < v && v < int'(cfg_cmax);
  endfunction

  function automatic bit gap_len(int v);
    return -int'(cfg_cmax) < v && v < -int'(cfg_cmin);
  endfunction

  function automatic bit hold_hit();
    return run_at(4) == int'(cfg_long);
  endfunction

  function automatic bit tap_once();
    return run_at(2) < -int'(cfg_cmax) && click_len(run_at(3)) && run_at(4) == -1;
  endfunction

  function automatic bit tap_twice();
    return (run_at(0) == 0 || run_at(0) < -int'(cfg_cmax)) && click_len(run_at(1)) &&
           gap_len(run_at(2)) && click_len(run_at(3)) && run_at(4) == -1;
  endfunction

  function automatic bit gesture_pending();
    int h;
    int h0;
    int h1;
    int h2;
    int h3;
    int cmax;
    bit lp;
    bit dc;
    cmax = int'(cfg_cmax);
    if (run_at(3) == 0) h = 4;
    else if (run_at(2) == 0) h = 3;
    else if (run_at(1) == 0) h = 2;
    else if (run_at(0) == 0) h = 1;
    else h = 0;
    h0 = run_at(h);
    h1 = run_at(h + 1);
    h2 = run_at(h + 2);
    h3 = run_at(h + 3);
    lp = (0 < h0 && h0 < int'(cfg_long)) && h1 == 0;
    dc = ((0 < h0 && h0 < cmax) && h1 == 0) ||
         (click_len(h0) && (-cmax < h1 && h1 < 0) && h2 == 0) ||
         (click_len(h0) && gap_len(h1) && (0 < h2 && h2 < cmax) && h3 == 0);
    return lp || dc;
  endfunction

  task automatic take_sample(input logic pin);
    int s;
    int nw;
    win = {win[DEBOUNCE_SAMPLES-2:0], ~pin};
    s = (&win) ? 1 : ((win == '0) ? -1 : 0);
    nw = run_at(HISTORY_RUNS - 1);
    if (s == 0 || (s > 0 && nw > 0) || (s < 0 && nw < 0)) begin
      if (nw > 0) begin
        if (nw < int'(RUN_SAT_POS)) nw++;
      end else if (nw > int'(RUN_SAT_NEG)) begin
        nw--;
      end
      runs[HISTORY_RUNS-1] = run_t'(nw);
    end else begin
      for (int i = 0; i < HISTORY_RUNS - 1; i++) runs[i] = runs[i+1];
      runs[HISTORY_RUNS-1] = run_t'(s);
    end
  endtask

  task automatic advance_sequencer(input logic pin, input logic sub, input logic fin,
                                   output result_t res);
    action_t act;
    act = ACT_NONE;
    case (pmode)
      MODE_INITIAL: begin
        if (!cfg_woke) begin
          act   = ACT_NOT_PIN_WAKE;
          pmode = MODE_OFF;
        end else begin
          take_sample(pin);
          if (hold_hit()) begin
            pmode         = MODE_SETTLING;
            settle_to_rec = 1'b0;
            settle_cnt    = '0;
          end else if (tap_twice()) begin
            pmode         = MODE_SETTLING;
            settle_to_rec = 1'b1;
            settle_cnt    = '0;
          end else if (!gesture_pending()) begin
            act   = ACT_INVALID_WAKE;
            pmode = MODE_OFF;
          end
        end
      end
      MODE_SETTLING: begin
        take_sample(pin);
        settle_cnt = settle_cnt + 1'b1;
        if (settle_cnt >= SETTLE_LAST) begin
          settle_cnt = '0;
          if (settle_to_rec) begin
            act   = ACT_START_REC;
            pmode = MODE_RECORDING;
          end else begin
            act      = ACT_START_LINK;
            pmode    = MODE_IDLE;
            idle_cnt = '0;
          end
        end
      end
      MODE_RECORDING: begin
        take_sample(pin);
        if (fin) begin
          act   = ACT_REC_FINISHED;
          pmode = MODE_OFF;
        end else if (tap_twice()) begin
          act   = ACT_STOP_REC_OFF;
          pmode = MODE_OFF;
        end else if (hold_hit()) begin
          act      = ACT_STOP_REC_LINK;
          pmode    = MODE_IDLE;
          idle_cnt = '0;
        end
      end
      MODE_IDLE: begin
        if (sub) idle_cnt = '0;
        else if (idle_cnt != TIMER_MAX) idle_cnt = idle_cnt + 1'b1;
        if (idle_cnt > cfg_tmo) begin
          act   = ACT_IDLE_TIMEOUT;
          pmode = MODE_OFF;
        end else begin
          take_sample(pin);
          if (tap_once()) begin
            act   = ACT_SINGLE_CLICK;
            pmode = MODE_OFF;
          end
        end
      end
      default: pmode = MODE_OFF;
    endcase
    res.act  = act;
    res.mode = pmode;
  endtask

  function automatic void report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endfunction

  task automatic check_word(input logic [7:0] w);
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result word, action", int'(w[3:0]), 0);
      return;
    end
    want = pending_results.pop_front();
    words_checked++;
    act_seen[want.act]   = 1'b1;
    mode_seen[want.mode] = 1'b1;
    if (w[3:0] != want.act) report_mismatch("action", int'(w[3:0]), int'(want.act));
    if (w[6:4] != want.mode) report_mismatch("mode", int'(w[6:4]), int'(want.mode));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WOKE_BY_BUTTON: cfg_woke = value[0];
      REG_LONG_PRESS:     cfg_long = value[9:0];
      REG_CLICK_MIN:      cfg_cmin = value[9:0];
      REG_CLICK_MAX:      cfg_cmax = value[9:0];
      REG_IDLE_TIMEOUT:   cfg_tmo  = value[TIMER_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic send_word(input logic pin, input logic sub, input logic fin,
                           input bit typed, input result_t want);
    result_t outcome;
    if (!calm && choke_left == 0 && (items_sent / 100) % 3 != 2 &&
        $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_axis_tdata  <= {5'b0, fin, sub, pin};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    advance_sequencer(pin, sub, fin, outcome);
    pending_results.push_back(typed ? want : outcome);
    items_sent++;
  endtask

  // drop valid and let every result come back before a register write
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // button level in bursts, with single-sample bounce
  task automatic next_pin(input bit hold_ok, output logic pin);
    if (burst_left == 0) begin
      lvl = ~lvl;
      if ($urandom_range(0, 19) == 0 && (lvl || hold_ok))
        burst_left = $urandom_range(300, 1100);
      else
        burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    pin = lvl;
    if ($urandom_range(0, 15) == 0) pin = ~lvl;
  endtask

  function automatic void next_sub();
    if ($urandom_range(0, 11) == 0) sub_lvl = ~sub_lvl;
  endfunction

  initial begin : result_side
    int pause_left;
    pause_left = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (m_axis_tvalid && m_axis_tready) check_word(m_axis_tdata);
      if (choke_req) begin
        choke_req  = 1'b0;
        choke_left = CHOKE_CYCLES;
      end
      if (choke_left > 0) begin
        choke_left--;
        m_axis_tready <= 1'b0;
      end else if (pause_left > 0) begin
        pause_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && (cycle_count / 300) % 3 != 1 && $urandom_range(0, 9) == 0) begin
        pause_left = $urandom_range(0, 6);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic pin;
    int   n;
    int   off_left;
    win = '1;
    foreach (runs[k]) runs[k] = '0;
    runs[HISTORY_RUNS-1] = RUN_ONE;
    pmode         = MODE_INITIAL;
    settle_cnt    = '0;
    settle_to_rec = 1'b0;
    idle_cnt      = '0;
    cfg_woke      = 1'b1;
    cfg_long      = RST_LONG_PRESS;
    cfg_cmin      = RST_CLICK_MIN;
    cfg_cmax      = RST_CLICK_MAX;
    cfg_tmo       = RST_IDLE_TIMEOUT;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_WOKE_BY_BUTTON, 32'd1);
    write_reg(REG_LONG_PRESS, 32'd100);
    write_reg(REG_CLICK_MIN, 32'd0);
    write_reg(REG_CLICK_MAX, 32'd6);

    for (n = 0; n < DIR_N; n++)
      send_word(DIR_ROWS[n].pin, DIR_ROWS[n].sub, DIR_ROWS[n].fin, DIR_ROWS[n].typed,
                DIR_ROWS[n].want);
    n = 0;
    while (pmode == MODE_SETTLING && n < 40) begin
      send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'b0, NO_WANT);
      n++;
    end

    // recording with every gesture out of reach: run history and saturation only
    quiesce();
    write_reg(REG_LONG_PRESS, 32'd1023);
    write_reg(REG_CLICK_MIN, 32'd1023);
    write_reg(REG_CLICK_MAX, 32'd1);
    repeat (600) begin
      next_pin(1'b0, pin);
      next_sub();
      send_word(pin, sub_lvl, 1'b0, 1'b0, NO_WANT);
    end
    repeat (40) send_word(1'b1, sub_lvl, 1'b0, 1'b0, NO_WANT);

    // hold the button until the long press moves recording to idle
    quiesce();
    write_reg(REG_LONG_PRESS, 32'd50);
    write_reg(REG_CLICK_MIN, 32'd8);
    write_reg(REG_CLICK_MAX, 32'd30);
    n = 0;
    while (pmode == MODE_RECORDING && n < 200) begin
      send_word(1'b0, sub_lvl, 1'b0, 1'b0, NO_WANT);
      n++;
    end

    // idle noise, no click and no timeout possible; receiver chokes part way
    quiesce();
    write_reg(REG_CLICK_MIN, 32'd1023);
    write_reg(REG_CLICK_MAX, 32'd1023);
    write_reg(REG_IDLE_TIMEOUT, 32'd32767);
    for (n = 0; n < 700; n++) begin
      if (n == 200) choke_req = 1'b1;
      next_pin(1'b1, pin);
      next_sub();
      send_word(pin, sub_lvl, 1'($urandom_range(0, 1)), 1'b0, NO_WANT);
    end

    // subscription drops up to the timeout, never past it
    quiesce();
    write_reg(REG_IDLE_TIMEOUT, 32'd25);
    off_left = 0;
    repeat (300) begin
      next_pin(1'b1, pin);
      send_word(pin, off_left == 0, 1'($urandom_range(0, 1)), 1'b0, NO_WANT);
      if (off_left > 0) off_left--;
      else if ($urandom_range(0, 7) == 0)
        off_left = ($urandom_range(0, 3) == 0) ? 25 : $urandom_range(1, 25);
    end

    // single click ends idle
    quiesce();
    write_reg(REG_CLICK_MIN, 32'd8);
    write_reg(REG_CLICK_MAX, 32'd30);
    write_reg(REG_IDLE_TIMEOUT, 32'd1);
    repeat (40) send_word(1'b1, 1'b1, 1'b0, 1'b0, NO_WANT);
    repeat (15) send_word(1'b0, 1'b1, 1'b1, 1'b0, NO_WANT);
    n = 0;
    while (pmode == MODE_IDLE && n < 20) begin
      send_word(1'b1, 1'b1, 1'b0, 1'b0, NO_WANT);
      n++;
    end

    // off holds whatever comes, no idling from here on
    quiesce();
    calm = 1'b1;
    write_reg(REG_WOKE_BY_BUTTON, 32'd0);
    write_reg(REG_LONG_PRESS, 32'd1);
    repeat (150)
      send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'b0, NO_WANT);
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d words and checked %0d results across %0d register writes.",
             items_sent, words_checked, reg_writes);
    $display("Actions seen (bit per code) %b, modes seen %b, mismatches %0d.",
             act_seen, mode_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** button_gesture_power_sequencer: PASSED **");
    end else begin
      $display("** button_gesture_power_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/bgps_pkg.sv
rtl/button_gesture_power_sequencer.sv
tb/tb_top.sv
